### hdl/hkst_pkg.sv
// Package with shared types and constants of the hash keyed sorted table.
`timescale 1ns / 1ps
package hkst_pkg;
  localparam logic [63:0] HASH_SEED = 64'd5381;
  localparam logic [30:0] HASH_MODULUS = 31'h7fffffff;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_DECIDE,
    BK_SHIFT_UP,
    BK_SHIFT_DOWN,
    BK_WRITE,
    BK_RESULT
  } back_state_t;

  // One key operation handed from the hashing front to the table back end.
  typedef struct packed {
    action_t     action;
    logic [30:0] key_hash;
    logic [31:0] insert_value;
  } key_op_t;
endpackage

### hdl/hkst_if.sv
// Valid/ready channel interfaces for input and result transfers.
`timescale 1ns / 1ps
interface hkst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  key_byte;
  logic        byte_present;
  logic        key_last;
  logic [31:0] insert_value;
  modport source (output valid, action, key_byte, byte_present, key_last, insert_value,
                  input ready);
  modport sink (input valid, action, key_byte, byte_present, key_last, insert_value,
                output ready);
endinterface

interface hkst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_value;
  logic [6:0]  entry_count;
  logic [30:0] key_hash;
  modport source (output valid, status, found_value, entry_count, key_hash, input ready);
  modport sink (input valid, status, found_value, entry_count, key_hash, output ready);
endinterface

### hdl/hkst_front.sv
// Front end: djb2 accumulation per byte and reduction mod 2^31-1 on the last byte.
`timescale 1ns / 1ps
module hkst_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_key_byte,
  input  logic                 in_byte_present,
  input  logic                 in_key_last,
  input  logic [31:0]          in_insert_value,
  output logic                 op_valid,
  input  logic                 op_ready,
  output hkst_pkg::key_op_t    op_data
);
  // Reduction runs in three folding steps, one per cycle: 64 -> 34 -> 32 -> 31 bits.
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] red_r, red_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic [1:0]  act_r, act_nxt;
  logic [31:0] val_r, val_nxt;
  logic        ov_r, ov_nxt;
  hkst_pkg::key_op_t od_r, od_nxt;
  logic [63:0] folded;
  logic [63:0] mixed;
  logic        take;

  assign in_ready = !busy_r && !ov_r;
  assign take     = in_valid && in_ready;
  assign op_valid = ov_r;
  assign op_data  = od_r;
  assign mixed    = in_byte_present ? ((acc_r << 5) + acc_r + {56'd0, in_key_byte}) : acc_r;
  // 2^31 == 1 mod M, so fold the high part onto the low 31 bits.
  assign folded   = {33'd0, red_r[30:0]} + {31'd0, red_r[63:31]};

  always_comb begin
    acc_nxt  = acc_r;
    red_nxt  = red_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    act_nxt  = act_r;
    val_nxt  = val_r;
    ov_nxt   = ov_r && !op_ready;
    od_nxt   = od_r;
    if (take) begin
      if (in_key_last) begin
        acc_nxt  = hkst_pkg::HASH_SEED;
        red_nxt  = mixed;
        step_nxt = 2'd0;
        busy_nxt = 1'b1;
        act_nxt  = in_action;
        val_nxt  = in_insert_value;
      end else begin
        acc_nxt = mixed;
      end
    end else if (busy_r) begin
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        ov_nxt   = 1'b1;
        od_nxt.action       = hkst_pkg::action_t'(act_r);
        od_nxt.insert_value = val_r;
        od_nxt.key_hash     = (red_r[30:0] == hkst_pkg::HASH_MODULUS) ? 31'd0 : red_r[30:0];
      end else begin
        red_nxt  = folded;
        step_nxt = step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= hkst_pkg::HASH_SEED;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      step_r <= 2'd0;
    end else begin
      acc_r  <= acc_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      step_r <= step_nxt;
    end
    red_r <= red_nxt;
    act_r <= act_nxt;
    val_r <= val_nxt;
    od_r  <= od_nxt;
  end
endmodule

### hdl/hkst_back.sv
// Back end: sorted table in memory with linear search, shift and result register.
`timescale 1ns / 1ps
module hkst_back #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_valid,
  output logic              op_ready,
  input  hkst_pkg::key_op_t op_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [31:0]       out_found_value,
  output logic [6:0]        out_entry_count,
  output logic [30:0]       out_key_hash
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [30:0]            hash_mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem  [TABLE_DEPTH];

  hkst_pkg::back_state_t state_r, state_nxt;
  hkst_pkg::key_op_t     op_r, op_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic [30:0]           rd_hash_r;
  logic [VALUE_WIDTH-1:0] rd_val_r;
  logic [1:0]            st_r, st_nxt;
  logic [31:0]           fv_r, fv_nxt;
  logic                  ov_r, ov_nxt;
  logic [1:0]            ost_r;
  logic [31:0]           ofv_r;
  logic [CW-1:0]         ocnt_r;
  logic [30:0]           ohash_r;
  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic [AW-1:0]         wr_addr;
  logic [30:0]           wr_hash;
  logic [VALUE_WIDTH-1:0] wr_val;
  logic                  hit;
  logic [VALUE_WIDTH-1:0] ins_val;

  assign ins_val = VALUE_WIDTH'(op_r.insert_value);
  assign hit = (pos_r < cnt_r) && (rd_hash_r == op_r.key_hash);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hkst_pkg::BK_IDLE:   if (op_valid) state_nxt = hkst_pkg::BK_SEARCH;
      hkst_pkg::BK_SEARCH:
        // rd_hash_r holds entry idx_r-1 after a read issued last cycle.
        if (idx_r == cnt_r || (idx_r != '0 && rd_hash_r >= op_r.key_hash))
          state_nxt = hkst_pkg::BK_DECIDE;
      hkst_pkg::BK_DECIDE: begin
        state_nxt = hkst_pkg::BK_RESULT;
        case (op_r.action)
          hkst_pkg::ACT_INSERT:
            if (!hit && cnt_r < DEPTH_C)
              state_nxt = (cnt_r == pos_r) ? hkst_pkg::BK_WRITE : hkst_pkg::BK_SHIFT_UP;
          hkst_pkg::ACT_REMOVE:
            if (hit) state_nxt = hkst_pkg::BK_SHIFT_DOWN;
          default: state_nxt = hkst_pkg::BK_RESULT;
        endcase
      end
      hkst_pkg::BK_SHIFT_UP:   if (idx_r == pos_r + 1'b1) state_nxt = hkst_pkg::BK_WRITE;
      hkst_pkg::BK_SHIFT_DOWN: if (idx_r + 1'b1 >= cnt_r) state_nxt = hkst_pkg::BK_RESULT;
      hkst_pkg::BK_WRITE:  state_nxt = hkst_pkg::BK_RESULT;
      hkst_pkg::BK_RESULT: if (!ov_r || out_ready) state_nxt = hkst_pkg::BK_IDLE;
      default: state_nxt = hkst_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    op_ready = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    pos_nxt  = pos_r;
    st_nxt   = st_r;
    fv_nxt   = fv_r;
    ov_nxt   = ov_r && !out_ready;
    rd_addr  = idx_r[AW-1:0];
    we       = 1'b0;
    wr_addr  = idx_r[AW-1:0];
    wr_hash  = rd_hash_r;
    wr_val   = rd_val_r;
    case (state_r)
      hkst_pkg::BK_IDLE: begin
        op_ready = 1'b1;
        op_nxt   = op_data;
        idx_nxt  = '0;
        pos_nxt  = '0;
        rd_addr  = '0;
      end
      hkst_pkg::BK_SEARCH: begin
        if (idx_r == cnt_r || (idx_r != '0 && rd_hash_r >= op_r.key_hash)) begin
          pos_nxt = (idx_r != '0 && rd_hash_r >= op_r.key_hash) ? idx_r - 1'b1 : idx_r;
          rd_addr = pos_nxt[AW-1:0];
        end else begin
          rd_addr = idx_r[AW-1:0];
          idx_nxt = idx_r + 1'b1;
        end
      end
      hkst_pkg::BK_DECIDE: begin
        st_nxt = hkst_pkg::ST_OK;
        fv_nxt = '0;
        case (op_r.action)
          hkst_pkg::ACT_LOOKUP: begin
            if (hit) fv_nxt = 32'(rd_val_r);
            else     st_nxt = hkst_pkg::ST_NOT_FOUND;
          end
          hkst_pkg::ACT_INSERT: begin
            if (hit)                 st_nxt = hkst_pkg::ST_DUPLICATE;
            else if (cnt_r >= DEPTH_C) st_nxt = hkst_pkg::ST_FULL;
          end
          hkst_pkg::ACT_REMOVE: if (!hit) st_nxt = hkst_pkg::ST_NOT_FOUND;
          default: st_nxt = hkst_pkg::ST_OK;
        endcase
        // Prepare the first read of a shift.
        idx_nxt = (op_r.action == hkst_pkg::ACT_REMOVE) ? pos_r : cnt_r;
        rd_addr = (op_r.action == hkst_pkg::ACT_REMOVE) ? AW'(pos_r + 1'b1)
                                                        : AW'(cnt_r - 1'b1);
      end
      hkst_pkg::BK_SHIFT_UP: begin
        // Entry idx-1 was read last cycle; it moves to idx.
        we      = 1'b1;
        wr_addr = idx_r[AW-1:0];
        idx_nxt = idx_r - 1'b1;
        rd_addr = AW'(idx_r - 2'd2);
      end
      hkst_pkg::BK_SHIFT_DOWN: begin
        // Entry idx+1 was read last cycle; it moves to idx.
        if (idx_r + 1'b1 < cnt_r) we = 1'b1;
        wr_addr = idx_r[AW-1:0];
        idx_nxt = idx_r + 1'b1;
        rd_addr = AW'(idx_r + 2'd2);
        if (idx_r + 1'b1 >= cnt_r) cnt_nxt = cnt_r - 1'b1;
      end
      hkst_pkg::BK_WRITE: begin
        we      = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_hash = op_r.key_hash;
        wr_val  = ins_val;
        cnt_nxt = cnt_r + 1'b1;
      end
      hkst_pkg::BK_RESULT: begin
        if (!ov_r || out_ready) ov_nxt = 1'b1;
      end
      default: op_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_hash_r <= hash_mem[rd_addr];
    rd_val_r  <= val_mem[rd_addr];
    if (we) begin
      hash_mem[wr_addr] <= wr_hash;
      val_mem[wr_addr]  <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hkst_pkg::BK_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    op_r  <= op_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    st_r  <= st_nxt;
    fv_r  <= fv_nxt;
    if (state_r == hkst_pkg::BK_RESULT && (!ov_r || out_ready)) begin
      ost_r   <= st_r;
      ofv_r   <= fv_r;
      ocnt_r  <= cnt_r;
      ohash_r <= op_r.key_hash;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_found_value = ofv_r;
  assign out_entry_count = 7'(ocnt_r);
  assign out_key_hash    = ohash_r;
endmodule

### hdl/hash_keyed_sorted_table.sv
// Top level of the hash keyed sorted table.
// Operation: non-final key bytes accumulate into the hash; a final byte starts the hash
// reduction, then a linear search over the N entries and, on insert or remove, a shift,
// all through the table memory. Throughput: one byte per cycle while a key streams and
// no finished operation waits for the back; one key operation at a time.
// Reset is synchronous, active low; it empties the table and reloads the hash seed.
`timescale 1ns / 1ps
module hash_keyed_sorted_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  hkst_in_if.sink    in_ch,
  hkst_out_if.source out_ch
);
  // The front hashes the key and hands one finished operation to the back through a
  // one-entry register, so the front can take new bytes while the back searches.
  logic              op_valid;
  logic              op_ready;
  hkst_pkg::key_op_t op_data;

  hkst_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_action(in_ch.action), .in_key_byte(in_ch.key_byte),
    .in_byte_present(in_ch.byte_present), .in_key_last(in_ch.key_last),
    .in_insert_value(in_ch.insert_value),
    .op_valid, .op_ready, .op_data
  );

  // The back keeps the table sorted by hash and emits one result per key transfer.
  hkst_back #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst_n,
    .op_valid, .op_ready, .op_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.status), .out_found_value(out_ch.found_value),
    .out_entry_count(out_ch.entry_count), .out_key_hash(out_ch.key_hash)
  );
endmodule

### hdl/hkst_checker.sv
// Port-level checker for the hash keyed sorted table and its bind.
`timescale 1ns / 1ps
module hkst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_found_value,
  input logic [6:0]  out_entry_count
);
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != hkst_pkg::ST_OK |-> 1'b1 && (out_found_value == 32'd0))
    else $error("found_value nonzero on failed result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 7'd64)
    else $error("entry count out of range");
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == hkst_pkg::ST_FULL |-> out_entry_count == 7'd64)
    else $error("full reported below capacity");
endmodule

bind hash_keyed_sorted_table hkst_checker u_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_found_value(out_ch.found_value),
  .out_entry_count(out_ch.entry_count)
);
